// ----- rtl/assert_macros.svh -----
// Assertion macros used by the top-level RTL file of the gravity projection block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/imu_gp_pkg.sv -----
// Types and constants of the IMU gyro and gravity projection block.
package imu_gp_pkg;

  // Gyro scaling: rad/s * 1024 = raw * RATE_K / 2^RATE_SHIFT.
  localparam logic [24:0] RATE_K     = 25'd18301104;
  localparam int          RATE_SHIFT = 24;

  // One in Q.29, the scale of the gravity components before normalizing.
  localparam logic signed [32:0] QUAT_ONE_SQ = 33'sd536870912;

  // Squared norm at or below this is treated as zero length.
  localparam logic [63:0] NORM_SQ_MIN = 64'd288230;

  // Unit length of the gravity output in Q1.14.
  localparam logic [15:0] GRAV_ONE  = 16'd16384;
  localparam int          GRAV_FRAC = 14;

  // Pipeline section lengths.
  localparam int NORM_STEPS = 5;   // binary search for the even left shift
  localparam int SQRT_STEPS = 32;  // one root bit per stage
  localparam int DIV_STEPS  = 16;  // one quotient bit per stage

  // Side data that rides along with each beat.
  typedef struct packed {
    logic signed [16:0] om0;
    logic signed [16:0] om1;
    logic signed [16:0] om2;
    logic [2:0]         neg;  // sign of a, b, c
    logic               ok;   // norm large enough to normalize
  } side_t;

endpackage

// ----- rtl/imu_gp_if.sv -----
// Valid/ready channel interfaces for IMU samples and projected results.
interface imu_gp_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] rate_raw_x;
  logic signed [15:0] rate_raw_y;
  logic signed [15:0] rate_raw_z;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;

  modport source (output valid, rate_raw_x, rate_raw_y, rate_raw_z,
                  quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink   (input valid, rate_raw_x, rate_raw_y, rate_raw_z,
                  quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface imu_gp_out_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] omega_0;
  logic signed [16:0] omega_1;
  logic signed [16:0] omega_2;
  logic signed [15:0] grav_0;
  logic signed [15:0] grav_1;
  logic signed [15:0] grav_2;

  modport source (output valid, omega_0, omega_1, omega_2,
                  grav_0, grav_1, grav_2, input ready);
  modport sink   (input valid, omega_0, omega_1, omega_2,
                  grav_0, grav_1, grav_2, output ready);
endinterface

// ----- rtl/imu_gyro_gravity_projection.sv -----
// Top level: gyro rate scaling and normalized gravity from a quaternion.
`include "assert_macros.svh"

// Takes one IMU sample per clock while the output is not held and returns
// one result beat per sample. The datapath is a single pipeline: products,
// gravity components, squares, squared norm, a five-stage even left shift,
// a 32-stage bit-per-cycle square root, a rounding-offset stage, three
// 16-stage bit-per-cycle dividers and the output register. The whole
// pipeline advances together; while a result waits in the output register
// with ready low, it holds and in_ch.ready is low. When the squared norm is
// tiny the gravity outputs are zero, which is what rounding the unnormalized
// components to Q1.14 gives in that range.
module imu_gyro_gravity_projection
  import imu_gp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  imu_gp_in_if.sink    in_ch,
  imu_gp_out_if.source out_ch
);

  logic pipe_en;
  logic out_vld_r;

  // The pipeline moves whenever the output register is free or being taken.
  assign pipe_en     = !out_vld_r || out_ch.ready;
  assign in_ch.ready = pipe_en;

  // ---------------------------------------------------------------------
  // Stage 1: quaternion products and gyro scaling products.
  // ---------------------------------------------------------------------
  logic                    s1_vld_r;
  logic signed [31:0]      s1_xz_r, s1_wy_r, s1_yz_r, s1_wx_r, s1_xx_r, s1_yy_r;
  logic [2:0][40:0]        s1_p_r;
  logic [2:0]              s1_rneg_r;
  logic signed [31:0]      qw, qx, qy, qz;
  logic [2:0][15:0]        rmag;
  logic [2:0]              rneg;
  logic [2:0][15:0]        rraw;

  assign qw = 32'(in_ch.quat_w);
  assign qx = 32'(in_ch.quat_x);
  assign qy = 32'(in_ch.quat_y);
  assign qz = 32'(in_ch.quat_z);
  assign rraw[0] = in_ch.rate_raw_x;
  assign rraw[1] = in_ch.rate_raw_y;
  assign rraw[2] = in_ch.rate_raw_z;

  // Gyro magnitudes; the most negative code maps to 32768.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rneg[c] = rraw[c][15];
      rmag[c] = rneg[c] ? 16'(-rraw[c]) : rraw[c];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (pipe_en) begin
      s1_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s1_xz_r   <= qx * qz;
      s1_wy_r   <= qw * qy;
      s1_yz_r   <= qy * qz;
      s1_wx_r   <= qw * qx;
      s1_xx_r   <= qx * qx;
      s1_yy_r   <= qy * qy;
      s1_rneg_r <= rneg;
      for (int c = 0; c < 3; c++) begin
        s1_p_r[c] <= 41'(rmag[c]) * 41'(RATE_K);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: gravity components in Q.29, magnitudes, rounded rates.
  // ---------------------------------------------------------------------
  logic             s2_vld_r;
  logic [2:0][31:0] s2_m_r;
  side_t            s2_side_r;
  logic signed [32:0] ga, gb, gc;
  logic [2:0][31:0] s2_m_nxt;
  side_t            s2_side_nxt;
  logic [2:0][16:0] rq;

  always_comb begin
    ga = 33'(s1_xz_r) - 33'(s1_wy_r);
    gb = 33'(s1_yz_r) + 33'(s1_wx_r);
    gc = QUAT_ONE_SQ - (33'(s1_xx_r) + 33'(s1_yy_r));
    s2_m_nxt[0] = ga[32] ? 32'(-ga) : 32'(ga);
    s2_m_nxt[1] = gb[32] ? 32'(-gb) : 32'(gb);
    s2_m_nxt[2] = gc[32] ? 32'(-gc) : 32'(gc);
    // Round magnitude to nearest, ties away from zero.
    for (int c = 0; c < 3; c++) begin
      rq[c] = 17'((s1_p_r[c] + (41'd1 << (RATE_SHIFT - 1))) >> RATE_SHIFT);
    end
    s2_side_nxt.om0 = s1_rneg_r[1] ? -$signed(rq[1]) : $signed(rq[1]);
    s2_side_nxt.om1 = s1_rneg_r[0] ? $signed(rq[0]) : -$signed(rq[0]);
    s2_side_nxt.om2 = s1_rneg_r[2] ? -$signed(rq[2]) : $signed(rq[2]);
    s2_side_nxt.neg = {gc[32], gb[32], ga[32]};
    s2_side_nxt.ok  = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (pipe_en) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s2_m_r    <= s2_m_nxt;
      s2_side_r <= s2_side_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: squares of the component magnitudes.
  // ---------------------------------------------------------------------
  logic             s3_vld_r;
  logic [2:0][63:0] s3_sq_r;
  logic [2:0][31:0] s3_m_r;
  side_t            s3_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (pipe_en) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int c = 0; c < 3; c++) begin
        s3_sq_r[c] <= 64'(s2_m_r[c]) * 64'(s2_m_r[c]);
      end
      s3_m_r    <= s2_m_r;
      s3_side_r <= s2_side_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: squared norm and the near-zero test.
  // ---------------------------------------------------------------------
  logic             s4_vld_r;
  logic [63:0]      s4_s_r;
  logic [2:0][31:0] s4_m_r;
  side_t            s4_side_r;
  logic [63:0]      s4_s_nxt;
  side_t            s4_side_nxt;

  always_comb begin
    s4_s_nxt       = s3_sq_r[0] + s3_sq_r[1] + s3_sq_r[2];
    s4_side_nxt    = s3_side_r;
    s4_side_nxt.ok = s4_s_nxt > NORM_SQ_MIN;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (pipe_en) begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s4_s_r    <= s4_s_nxt;
      s4_m_r    <= s3_m_r;
      s4_side_r <= s4_side_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Normalize: shift the squared norm left by 2k until its top pair is
  // nonzero, and the magnitudes by k, as a binary search over k.
  // ---------------------------------------------------------------------
  logic [NORM_STEPS-1:0]            nrm_vld_r;
  logic [NORM_STEPS-1:0][63:0]      nrm_s_r;
  logic [NORM_STEPS-1:0][2:0][31:0] nrm_m_r;
  side_t                            nrm_side_r [NORM_STEPS];

  for (genvar j = 0; j < NORM_STEPS; j++) begin : g_nrm
    localparam int Step = 1 << (NORM_STEPS - 1 - j);
    logic             vld_in;
    logic [63:0]      s_in;
    logic [2:0][31:0] m_in;
    side_t            side_in;
    logic [63:0]      s_nxt;
    logic [2:0][31:0] m_nxt;

    if (j == 0) begin : g_src
      assign vld_in  = s4_vld_r;
      assign s_in    = s4_s_r;
      assign m_in    = s4_m_r;
      assign side_in = s4_side_r;
    end else begin : g_src
      assign vld_in  = nrm_vld_r[j-1];
      assign s_in    = nrm_s_r[j-1];
      assign m_in    = nrm_m_r[j-1];
      assign side_in = nrm_side_r[j-1];
    end

    always_comb begin
      if (s_in[63 -: 2*Step] == '0) begin
        s_nxt = s_in << (2*Step);
        for (int c = 0; c < 3; c++) begin
          m_nxt[c] = m_in[c] << Step;
        end
      end else begin
        s_nxt = s_in;
        m_nxt = m_in;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        nrm_vld_r[j] <= 1'b0;
      end else if (pipe_en) begin
        nrm_vld_r[j] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (pipe_en) begin
        nrm_s_r[j]    <= s_nxt;
        nrm_m_r[j]    <= m_nxt;
        nrm_side_r[j] <= side_in;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Square root: one root bit per stage, restoring digit recurrence.
  // ---------------------------------------------------------------------
  logic [SQRT_STEPS-1:0]            sqrt_vld_r;
  logic [SQRT_STEPS-1:0][63:0]      sqrt_s_r;
  logic [SQRT_STEPS-1:0][33:0]      sqrt_rem_r;
  logic [SQRT_STEPS-1:0][31:0]      sqrt_root_r;
  logic [SQRT_STEPS-1:0][2:0][31:0] sqrt_m_r;
  side_t                            sqrt_side_r [SQRT_STEPS];

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    localparam int Pair = SQRT_STEPS - 1 - i;
    logic             vld_in;
    logic [63:0]      s_in;
    logic [33:0]      rem_in;
    logic [31:0]      root_in;
    logic [2:0][31:0] m_in;
    side_t            side_in;
    logic [35:0]      cand;
    logic [35:0]      trial;
    logic [33:0]      rem_nxt;
    logic [31:0]      root_nxt;

    if (i == 0) begin : g_src
      assign vld_in  = nrm_vld_r[NORM_STEPS-1];
      assign s_in    = nrm_s_r[NORM_STEPS-1];
      assign rem_in  = '0;
      assign root_in = '0;
      assign m_in    = nrm_m_r[NORM_STEPS-1];
      assign side_in = nrm_side_r[NORM_STEPS-1];
    end else begin : g_src
      assign vld_in  = sqrt_vld_r[i-1];
      assign s_in    = sqrt_s_r[i-1];
      assign rem_in  = sqrt_rem_r[i-1];
      assign root_in = sqrt_root_r[i-1];
      assign m_in    = sqrt_m_r[i-1];
      assign side_in = sqrt_side_r[i-1];
    end

    always_comb begin
      cand  = {rem_in, s_in[2*Pair+1 -: 2]};
      trial = 36'({root_in, 2'b01});
      if (cand >= trial) begin
        rem_nxt  = 34'(cand - trial);
        root_nxt = {root_in[30:0], 1'b1};
      end else begin
        rem_nxt  = 34'(cand);
        root_nxt = {root_in[30:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sqrt_vld_r[i] <= 1'b0;
      end else if (pipe_en) begin
        sqrt_vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (pipe_en) begin
        sqrt_s_r[i]    <= s_in;
        sqrt_rem_r[i]  <= rem_nxt;
        sqrt_root_r[i] <= root_nxt;
        sqrt_m_r[i]    <= m_in;
        sqrt_side_r[i] <= side_in;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Dividend with the rounding offset: (m << 14) + floor(r / 2).
  // ---------------------------------------------------------------------
  logic             dp_vld_r;
  logic [2:0][46:0] dp_n_r;
  logic [31:0]      dp_r_r;
  side_t            dp_side_r;
  logic [31:0]      root_fin;

  assign root_fin = sqrt_root_r[SQRT_STEPS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dp_vld_r <= 1'b0;
    end else if (pipe_en) begin
      dp_vld_r <= sqrt_vld_r[SQRT_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int c = 0; c < 3; c++) begin
        dp_n_r[c] <= (47'(sqrt_m_r[SQRT_STEPS-1][c]) << GRAV_FRAC)
                     + 47'(root_fin[31:1]);
      end
      dp_r_r    <= root_fin;
      dp_side_r <= sqrt_side_r[SQRT_STEPS-1];
    end
  end

  // ---------------------------------------------------------------------
  // Three restoring dividers by the root, one quotient bit per stage.
  // The dividend is below r * 2^16, so 16 quotient bits suffice.
  // ---------------------------------------------------------------------
  logic [DIV_STEPS-1:0]            div_vld_r;
  logic [DIV_STEPS-1:0][2:0][31:0] div_rem_r;
  logic [DIV_STEPS-1:0][2:0][15:0] div_lo_r;
  logic [DIV_STEPS-1:0][2:0][15:0] div_q_r;
  logic [DIV_STEPS-1:0][31:0]      div_d_r;
  side_t                           div_side_r [DIV_STEPS];

  for (genvar t = 0; t < DIV_STEPS; t++) begin : g_div
    localparam int Bit = DIV_STEPS - 1 - t;
    logic             vld_in;
    logic [2:0][31:0] rem_in;
    logic [2:0][15:0] lo_in;
    logic [2:0][15:0] q_in;
    logic [31:0]      d_in;
    side_t            side_in;
    logic [2:0][32:0] cand;
    logic [2:0][31:0] rem_nxt;
    logic [2:0][15:0] q_nxt;

    if (t == 0) begin : g_src
      assign vld_in  = dp_vld_r;
      assign d_in    = dp_r_r;
      assign side_in = dp_side_r;
      assign q_in    = '0;
      for (genvar c = 0; c < 3; c++) begin : g_lane
        assign rem_in[c] = 32'(dp_n_r[c][46:16]);
        assign lo_in[c]  = dp_n_r[c][15:0];
      end
    end else begin : g_src
      assign vld_in  = div_vld_r[t-1];
      assign d_in    = div_d_r[t-1];
      assign side_in = div_side_r[t-1];
      assign q_in    = div_q_r[t-1];
      assign rem_in  = div_rem_r[t-1];
      assign lo_in   = div_lo_r[t-1];
    end

    always_comb begin
      for (int c = 0; c < 3; c++) begin
        cand[c] = {rem_in[c], lo_in[c][Bit]};
        if (cand[c] >= {1'b0, d_in}) begin
          rem_nxt[c] = 32'(cand[c] - {1'b0, d_in});
          q_nxt[c]   = {q_in[c][14:0], 1'b1};
        end else begin
          rem_nxt[c] = 32'(cand[c]);
          q_nxt[c]   = {q_in[c][14:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        div_vld_r[t] <= 1'b0;
      end else if (pipe_en) begin
        div_vld_r[t] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (pipe_en) begin
        div_rem_r[t]  <= rem_nxt;
        div_lo_r[t]   <= lo_in;
        div_q_r[t]    <= q_nxt;
        div_d_r[t]    <= d_in;
        div_side_r[t] <= side_in;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output register: saturate, apply signs and the axis remap.
  // ---------------------------------------------------------------------
  logic signed [16:0] out_om0_r, out_om1_r, out_om2_r;
  logic signed [15:0] out_g0_r, out_g1_r, out_g2_r;
  logic [2:0][15:0]   qsat;
  side_t              fin_side;
  logic signed [15:0] g0_nxt, g1_nxt, g2_nxt;

  assign fin_side = div_side_r[DIV_STEPS-1];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      qsat[c] = (div_q_r[DIV_STEPS-1][c] > GRAV_ONE) ? GRAV_ONE
                                                    : div_q_r[DIV_STEPS-1][c];
    end
    // Output is (-gb, ga, -gc); a tiny norm gives all zeros.
    if (fin_side.ok) begin
      g0_nxt = fin_side.neg[1] ? $signed(qsat[1]) : -$signed(qsat[1]);
      g1_nxt = fin_side.neg[0] ? -$signed(qsat[0]) : $signed(qsat[0]);
      g2_nxt = fin_side.neg[2] ? $signed(qsat[2]) : -$signed(qsat[2]);
    end else begin
      g0_nxt = '0;
      g1_nxt = '0;
      g2_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (pipe_en) begin
      out_vld_r <= div_vld_r[DIV_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      out_om0_r <= fin_side.om0;
      out_om1_r <= fin_side.om1;
      out_om2_r <= fin_side.om2;
      out_g0_r  <= g0_nxt;
      out_g1_r  <= g1_nxt;
      out_g2_r  <= g2_nxt;
    end
  end

  assign out_ch.valid   = out_vld_r;
  assign out_ch.omega_0 = out_om0_r;
  assign out_ch.omega_1 = out_om1_r;
  assign out_ch.omega_2 = out_om2_r;
  assign out_ch.grav_0  = out_g0_r;
  assign out_ch.grav_1  = out_g1_r;
  assign out_ch.grav_2  = out_g2_r;

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  // A stall freezes every beat in the square root section.
  `ASSERT_NEXT(a_sqrt_hold, clk, rst_n, !pipe_en, $stable(sqrt_vld_r), "sqrt beats moved in stall")
  // After the even shift the squared norm is at least 2^62, so the root MSB is set.
  `ASSERT_IMPLIES(a_root_msb, clk, rst_n, dp_vld_r && dp_side_r.ok, dp_r_r[31], "root below 2^31")
  // Gravity outputs stay within plus or minus one.
  `ASSERT_IMPLIES(a_grav_range, clk, rst_n, out_vld_r, (out_g0_r >= -16'sd16384) && (out_g0_r <= 16'sd16384) && (out_g1_r >= -16'sd16384) && (out_g1_r <= 16'sd16384) && (out_g2_r >= -16'sd16384) && (out_g2_r <= 16'sd16384), "gravity out of range")
  // Rate outputs stay within the full-scale range.
  `ASSERT_IMPLIES(a_rate_range, clk, rst_n, out_vld_r, (out_om0_r >= -17'sd35745) && (out_om0_r <= 17'sd35745) && (out_om1_r >= -17'sd35745) && (out_om1_r <= 17'sd35745) && (out_om2_r >= -17'sd35745) && (out_om2_r <= 17'sd35745), "rate out of range")

endmodule
